@@ hw/rtl/trht_pkg.sv @@
// trht_pkg: shared types, constants and calibration coefficients for the
// touch region hit table; no dependencies
package trht_pkg;

  localparam int PAGES_DEF         = 8;
  localparam int LAYERS_DEF        = 4;
  localparam int SLOTS_DEF         = 16;
  localparam int SCREEN_WIDTH_DEF  = 480;
  localparam int SCREEN_HEIGHT_DEF = 272;
  localparam int MAX_RES           = 16;

  localparam logic signed [17:0] CAL_XA = 18'sd34269;
  localparam logic signed [17:0] CAL_XB = 18'sd184;
  localparam logic signed [35:0] CAL_XL = -36'sd2080978;
  localparam logic signed [17:0] CAL_YA = -18'sd262;
  localparam logic signed [17:0] CAL_YB = 18'sd23901;
  localparam logic signed [35:0] CAL_YL = -36'sd1496921;

  typedef enum logic [1:0] {
    ACT_REG   = 2'd0,
    ACT_UNREG = 2'd1,
    ACT_TOUCH = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    RPL_REGISTERED = 3'd0,
    RPL_FULL       = 3'd1,
    RPL_UNREG      = 3'd2,
    RPL_HIT        = 3'd3,
    RPL_NOHIT      = 3'd4,
    RPL_REJECT     = 3'd5
  } reply_t;

  localparam logic [1:0] CFG_PAGE  = 2'd0;
  localparam logic [1:0] CFG_LAYER = 2'd1;
  localparam logic [1:0] CFG_MASK  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  page;
    logic [1:0]  layer;
    logic [3:0]  slot_index;
    logic [9:0]  left;
    logic [9:0]  top;
    logic [9:0]  right;
    logic [9:0]  bottom;
    logic [3:0]  kind;
    logic [15:0] ident;
    logic [15:0] raw_first;
    logic [15:0] raw_second;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  reply;
    logic [3:0]  found_slot;
    logic [3:0]  hit_kind;
    logic [15:0] hit_ident;
    logic [9:0]  screen_x;
    logic [9:0]  screen_y;
    logic        last;
  } out_item_t;

  // table entry: edges, kind, ident, live
  typedef struct packed {
    logic [9:0]  left;
    logic [9:0]  top;
    logic [9:0]  right;
    logic [9:0]  bottom;
    logic [3:0]  kind;
    logic [15:0] ident;
    logic        live;
  } entry_t;

  // shared multiply-accumulate operation select
  typedef struct packed {
    logic              en;
    logic              clr;
    logic signed [17:0] coef;
    logic signed [17:0] opnd;
  } mac_ctl_t;

endpackage

@@ hw/rtl/touch_region_hit_table_top.sv @@
// touch_region_hit_table_top: sequencer, element table memory and config
// depends on trht_pkg, trht_mac
// sequence: register reads slots until a free one, unregister writes one slot, touch
// calibrates and then scans every slot of the shown page and layer; a rejected touch stops after the check
// throughput: one item at a time, busy drops in the cycle of the last result
// results are strobed for one cycle each; the receiver cannot stall
// reset: after rst_n a clearing pass writes every table entry to zero while busy stays high
module touch_region_hit_table_top import trht_pkg::*; #(
  parameter int PAGES         = PAGES_DEF,
  parameter int LAYERS        = LAYERS_DEF,
  parameter int SLOTS         = SLOTS_DEF,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DEPTH = PAGES * LAYERS * SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_FIND  = 10'b0000000100,
    ST_UNREG = 10'b0000001000,
    ST_CAL   = 10'b0000010000,
    ST_CHK   = 10'b0000100000,
    ST_SCAN  = 10'b0001000000,
    ST_TEST  = 10'b0010000000,
    ST_NOHIT = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]  shown_page_r;
  logic [1:0]  shown_layer_r;
  logic [15:0] mask_r;

  entry_t      mem [DEPTH];
  entry_t      rd_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  entry_t        wr_data;

  in_item_t    item_r;
  logic [AW:0] clr_r;
  logic [SW:0] cnt_r, cnt_nxt;     // slot counter, reads in flight
  logic [SW:0] tst_r;              // slot of entry in rd_r
  logic [4:0]  hits_r;
  logic [3:0]  step_r;
  logic [AW-1:0] base_r;
  logic          rd_pend_r;

  logic [15:0] rx, ry;
  logic        raw_ok_r;
  logic signed [35:0] ax_r, ay_r;
  logic [9:0]  sx_r, sy_r;
  logic        cal_ok;

  mac_ctl_t           mac_ctl;
  logic signed [35:0] mac_init, mac_acc;

  out_item_t out_r, out_nxt;
  logic      strobe_r, strobe_nxt;

  // hit output: up to MAX_RES hits in the scan are emitted; last is fixed up by holding
  // each hit in pend_r and releasing it when the next is found, or at the end with last set
  out_item_t pend_r;
  logic      pend_v_r;

  trht_mac u_mac (.clk(clk), .ctl(mac_ctl), .init(mac_init), .acc(mac_acc));

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  assign rx = 16'd1024 - item_r.raw_second;
  assign ry = item_r.raw_first;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_page_r  <= '0;
      shown_layer_r <= '0;
      mask_r        <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PAGE:  shown_page_r  <= cfg_data[2:0];
        CFG_LAYER: shown_layer_r <= cfg_data[1:0];
        CFG_MASK:  mask_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [AW-1:0] tbl_base(input logic [2:0] pg, input logic [1:0] ly);
    logic [AW+6:0] t;
    t = ((AW+7)'(pg) * (AW+7)'(LAYERS) + (AW+7)'(ly)) * (AW+7)'(SLOTS);
    return t[AW-1:0];
  endfunction

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  // mac sequencing: step 0 clears to x offset, 1..2 add x terms,
  // 3 captures x and clears to y offset, 4..5 add y terms, 6 captures y
  always_comb begin
    mac_ctl  = '0;
    mac_init = CAL_XL;
    if (state_r == ST_CAL) begin
      case (step_r)
        4'd0: begin mac_ctl.clr = 1'b1; mac_ctl.en = 1'b1;
                    mac_ctl.coef = CAL_XA; mac_ctl.opnd = 18'($signed({1'b0, rx[10:0]})); end
        4'd1: begin mac_ctl.en = 1'b1;
                    mac_ctl.coef = CAL_XB; mac_ctl.opnd = 18'($signed({1'b0, ry[10:0]})); end
        4'd3: begin mac_ctl.clr = 1'b1; mac_init = CAL_YL; mac_ctl.en = 1'b1;
                    mac_ctl.coef = CAL_YA; mac_ctl.opnd = 18'($signed({1'b0, rx[10:0]})); end
        4'd4: begin mac_ctl.en = 1'b1;
                    mac_ctl.coef = CAL_YB; mac_ctl.opnd = 18'($signed({1'b0, ry[10:0]})); end
        default: ;
      endcase
    end
  end

  // truncation toward zero: negative unless the value is above -65536
  logic x_neg, y_neg;
  logic [19:0] x_int, y_int;
  assign x_neg = ax_r[35] && (ax_r < -36'sd65535);
  assign y_neg = ay_r[35] && (ay_r < -36'sd65535);
  assign x_int = ax_r[35] ? 20'd0 : ax_r[35:16];
  assign y_int = ay_r[35] ? 20'd0 : ay_r[35:16];
  assign cal_ok = raw_ok_r && !x_neg && !y_neg &&
                  (x_int <= 20'(SCREEN_WIDTH)) && (y_int <= 20'(SCREEN_HEIGHT));

  logic tbl_ok, shown_ok, ent_hit;
  assign tbl_ok   = (32'(in_item.page) < PAGES) && (32'(in_item.layer) < LAYERS);
  assign shown_ok = (32'(shown_page_r) < PAGES) && (32'(shown_layer_r) < LAYERS);
  assign ent_hit  = rd_r.live && !mask_r[rd_r.kind] &&
                    (sx_r >= rd_r.left) && (sx_r <= rd_r.right) &&
                    (sy_r >= rd_r.top) && (sy_r <= rd_r.bottom);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rd_addr    = base_r + AW'(cnt_r[SW-1:0]);
    wr_en      = 1'b0;
    wr_addr    = base_r + AW'(cnt_r[SW-1:0]);
    wr_data    = '0;
    out_nxt    = out_r;
    strobe_nxt = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r[AW-1:0];
        if (clr_r == (AW+1)'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cnt_nxt = '0;
          case (in_item.action)
            ACT_REG:   state_nxt = tbl_ok ? ST_FIND : ST_DONE;
            ACT_UNREG: state_nxt = tbl_ok ? ST_UNREG : ST_DONE;
            ACT_TOUCH: state_nxt = ST_CAL;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FIND: begin
        // rd_r holds slot tst_r when rd_pend_r
        if (rd_pend_r && !rd_r.live) begin
          wr_en   = 1'b1;
          wr_addr = base_r + AW'(tst_r[SW-1:0]);
          wr_data = '{left: item_r.left, top: item_r.top, right: item_r.right,
                      bottom: item_r.bottom, kind: item_r.kind, ident: item_r.ident,
                      live: 1'b1};
          out_nxt            = '0;
          out_nxt.reply      = RPL_REGISTERED;
          out_nxt.found_slot = 4'(tst_r);
          out_nxt.last       = 1'b1;
          strobe_nxt         = 1'b1;
          state_nxt = ST_IDLE;
        end else if (rd_pend_r && tst_r == (SW+1)'(SLOTS - 1)) begin
          out_nxt       = '0;
          out_nxt.reply = RPL_FULL;
          out_nxt.last  = 1'b1;
          strobe_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
        if (cnt_r < (SW+1)'(SLOTS)) cnt_nxt = cnt_r + 1'b1;
      end
      ST_UNREG: begin
        wr_en   = 32'(item_r.slot_index) < SLOTS;
        wr_addr = base_r + AW'(item_r.slot_index);
        out_nxt       = '0;
        out_nxt.reply = RPL_UNREG;
        out_nxt.last  = 1'b1;
        strobe_nxt    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_CAL: if (step_r == 4'd6) state_nxt = ST_CHK;
      ST_CHK: begin
        if (!cal_ok) begin
          out_nxt       = '0;
          out_nxt.reply = RPL_REJECT;
          out_nxt.last  = 1'b1;
          strobe_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end else if (!shown_ok) state_nxt = ST_NOHIT;
        else begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (cnt_r < (SW+1)'(SLOTS)) cnt_nxt = cnt_r + 1'b1;
        if (rd_pend_r && tst_r == (SW+1)'(SLOTS - 1)) state_nxt = ST_TEST;
        if (rd_pend_r && ent_hit && hits_r < 5'(MAX_RES) && pend_v_r) begin
          out_nxt    = pend_r;
          strobe_nxt = 1'b1;
        end
      end
      ST_TEST: state_nxt = (hits_r == 5'd0) ? ST_NOHIT : ST_DONE;
      ST_NOHIT: begin
        out_nxt          = '0;
        out_nxt.reply    = RPL_NOHIT;
        out_nxt.screen_x = sx_r;
        out_nxt.screen_y = sy_r;
        out_nxt.last     = 1'b1;
        strobe_nxt       = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_DONE: begin
        if (item_r.action == ACT_TOUCH) begin
          out_nxt      = pend_r;
          out_nxt.last = 1'b1;
        end else begin
          out_nxt       = '0;
          out_nxt.reply = (item_r.action == ACT_REG) ? RPL_FULL : RPL_UNREG;
          out_nxt.last  = 1'b1;
        end
        strobe_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      strobe_r  <= 1'b0;
      pend_v_r  <= 1'b0;
      rd_pend_r <= 1'b0;
      step_r    <= '0;
      cnt_r     <= '0;
      tst_r     <= '0;
      hits_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      strobe_r  <= strobe_nxt;
      out_r     <= out_nxt;
      tst_r     <= cnt_r;
      rd_pend_r <= ((state_r == ST_FIND) || (state_r == ST_SCAN)) &&
                   (cnt_r < (SW+1)'(SLOTS));
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == ST_CAL) step_r <= step_r + 1'b1;
      case (state_r)
        ST_IDLE: if (start) begin
          item_r   <= in_item;
          step_r   <= '0;
          hits_r   <= '0;
          pend_v_r <= 1'b0;
          case (in_item.action)
            ACT_REG:   base_r <= tbl_base(in_item.page, in_item.layer);
            ACT_UNREG: base_r <= tbl_base(in_item.page, in_item.layer);
            ACT_TOUCH: base_r <= tbl_base(shown_page_r, shown_layer_r);
            default: ;
          endcase
        end
        ST_CAL: begin
          if (step_r == 4'd0) raw_ok_r <= (rx <= 16'd1024) && (ry <= 16'd1024);
          if (step_r == 4'd3) ax_r <= mac_acc;
          if (step_r == 4'd6) ay_r <= mac_acc;
        end
        ST_CHK: begin
          sx_r <= x_int[9:0];
          sy_r <= y_int[9:0];
        end
        ST_SCAN: begin
          if (rd_pend_r && ent_hit && hits_r < 5'(MAX_RES)) begin
            pend_r.reply      <= RPL_HIT;
            pend_r.found_slot <= 4'(tst_r);
            pend_r.hit_kind   <= rd_r.kind;
            pend_r.hit_ident  <= rd_r.ident;
            pend_r.screen_x   <= sx_r;
            pend_r.screen_y   <= sy_r;
            pend_r.last       <= 1'b0;
            pend_v_r <= 1'b1;
            hits_r   <= hits_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/trht_mac.sv @@
// trht_mac: shared 18x18 multiply-accumulate unit used for calibration
// depends on trht_pkg
module trht_mac import trht_pkg::*; (
  input  logic               clk,
  input  mac_ctl_t           ctl,
  input  logic signed [35:0] init,
  output logic signed [35:0] acc
);

  logic signed [35:0] acc_r, acc_nxt;
  logic signed [35:0] prod_r;
  logic               add_r;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) acc_nxt = init;
    else if (add_r) acc_nxt = acc_r + prod_r;
  end

  always_ff @(posedge clk) begin
    prod_r <= ctl.coef * ctl.opnd;
    add_r  <= ctl.en;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

@@ hw/rtl/trht_checker.sv @@
// trht_checker: port-level checks for the touch region hit table
// depends on trht_pkg; bound to touch_region_hit_table_top
module trht_checker import trht_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_item
);

  // a last result ends the item, so the block is free in that cycle
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last |-> !busy)
    else $error("busy after last result");

  // results only while working on an item
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !$past(busy) |-> 1'b0)
    else $error("result without item");

  // only hits are followed by more results
  a_nonlast_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |-> out_item.reply == RPL_HIT)
    else $error("non-final result that is not a hit");

  // reply codes stay in range
  a_reply_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_item.reply <= RPL_REJECT)
    else $error("bad reply code");

endmodule

bind touch_region_hit_table_top trht_checker u_trht_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_strobe(out_strobe), .out_item(out_item)
);

@@ dv/tb_touch_region_hit_table_top.sv @@
// tb_touch_region_hit_table_top: self-checking bench for the touch region hit table
// predicts every result from a behavioral table model and compares each whole result
// depends on trht_pkg and touch_region_hit_table_top
module tb_touch_region_hit_table_top;
  import trht_pkg::*;

  localparam int NPAGES = PAGES_DEF;
  localparam int NLAYERS = LAYERS_DEF;
  localparam int NSLOTS = SLOTS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_strobe;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  touch_region_hit_table_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  entry_t elem_tbl [NPAGES*NLAYERS*NSLOTS];
  logic [2:0] cur_page;
  logic [1:0] cur_layer;
  logic [15:0] cur_mask;

  out_item_t expected_results [$];
  in_item_t pending_items [$];
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int gap_cnt = 0;
  bit drain_req = 0;

  function automatic out_item_t blank_result(reply_t r);
    out_item_t o;
    o = '0;
    o.reply = r;
    return o;
  endfunction

  // truncate Q16 toward zero
  function automatic longint q16_trunc(longint acc);
    if (acc < 0) return -((-acc) >>> 16);
    return acc >>> 16;
  endfunction

  task automatic predict_item(input in_item_t it);
    int base;
    int idx;
    int n;
    bit done;
    longint rx, ry, sx, sy;
    out_item_t o;
    entry_t e;
    n = 0;
    done = 0;
    case (it.action)
      ACT_REG: begin
        o = blank_result(RPL_FULL);
        base = (it.page * NLAYERS + it.layer) * NSLOTS;
        for (int i = 0; i < NSLOTS; i++) begin
          if (!done && !elem_tbl[base+i].live) begin
            elem_tbl[base+i] = '{it.left, it.top, it.right, it.bottom, it.kind, it.ident, 1'b1};
            o = blank_result(RPL_REGISTERED);
            o.found_slot = 4'(i);
            done = 1;
          end
        end
        o.last = 1;
        expected_results.push_back(o);
      end
      ACT_UNREG: begin
        idx = (it.page * NLAYERS + it.layer) * NSLOTS + it.slot_index;
        elem_tbl[idx] = '0;
        o = blank_result(RPL_UNREG);
        o.last = 1;
        expected_results.push_back(o);
      end
      ACT_TOUCH: begin
        ry = it.raw_first;
        rx = 16'(16'd1024 - it.raw_second);
        if (rx > 1024 || ry > 1024) begin
          done = 1;
        end else begin
          sx = q16_trunc(34269 * rx + 184 * ry - 2080978);
          sy = q16_trunc(-262 * rx + 23901 * ry - 1496921);
          if (sx < 0 || sy < 0 || sx > SCREEN_WIDTH_DEF || sy > SCREEN_HEIGHT_DEF) done = 1;
        end
        if (done) begin
          o = blank_result(RPL_REJECT);
          o.last = 1;
          expected_results.push_back(o);
        end else begin
          base = (cur_page * NLAYERS + cur_layer) * NSLOTS;
          for (int i = 0; i < NSLOTS; i++) begin
            e = elem_tbl[base+i];
            if (e.live && !cur_mask[e.kind] && n < MAX_RES &&
                sx >= e.left && sx <= e.right && sy >= e.top && sy <= e.bottom) begin
              o = blank_result(RPL_HIT);
              o.found_slot = 4'(i);
              o.hit_kind = e.kind;
              o.hit_ident = e.ident;
              o.screen_x = 10'(sx);
              o.screen_y = 10'(sy);
              expected_results.push_back(o);
              n++;
            end
          end
          if (n == 0) begin
            o = blank_result(RPL_NOHIT);
            o.screen_x = 10'(sx);
            o.screen_y = 10'(sy);
            expected_results.push_back(o);
          end
          expected_results[$].last = 1;
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
    end else if (start && !busy) begin
      predict_item(in_item);
      start <= 0;
      gap_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    end else if (!start) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
      end else if (pending_items.size() > 0 && !drain_req) begin
        in_item <= pending_items.pop_front();
        start <= 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t exp_o;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: actual %p", $time, out_item);
        fail_cnt++;
      end else begin
        exp_o = expected_results.pop_front();
        if (out_item !== exp_o) begin
          $display("%0t mismatch: expected %p actual %p", $time, exp_o, out_item);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic in_item_t rand_fields();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t mk_reg(int pg, int ly, int l, int t, int r, int b, int k);
    in_item_t it;
    it = rand_fields();
    it.action = ACT_REG;
    it.page = 3'(pg);
    it.layer = 2'(ly);
    it.left = 10'(l);
    it.top = 10'(t);
    it.right = 10'(r);
    it.bottom = 10'(b);
    it.kind = 4'(k);
    return it;
  endfunction

  function automatic in_item_t mk_unreg(int pg, int ly, int s);
    in_item_t it;
    it = rand_fields();
    it.action = ACT_UNREG;
    it.page = 3'(pg);
    it.layer = 2'(ly);
    it.slot_index = 4'(s);
    return it;
  endfunction

  // raw readings for screen point near (x, y): inverse of the calibration
  function automatic in_item_t mk_touch(int x, int y);
    in_item_t it;
    int rx;
    it = rand_fields();
    it.action = ACT_TOUCH;
    rx = ((x + 61) * 65536) / 34269 - 2;
    if (rx < 0) rx = 0;
    it.raw_second = 16'(1024 - rx);
    it.raw_first = 16'(((y + 64) * 65536) / 23901);
    return it;
  endfunction

  // sampled at the falling edge so driver updates have settled
  task automatic wait_idle();
    while (pending_items.size() > 0) @(negedge clk);
    drain_req = 1;
    while (start || expected_results.size() > 0 || busy) @(negedge clk);
    repeat (NSLOTS + 12) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      CFG_PAGE: cur_page = val[2:0];
      CFG_LAYER: cur_layer = val[1:0];
      CFG_MASK: cur_mask = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic run_phase(input int n_items);
    int sel;
    int x, y;
    in_item_t it;
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 19);
      x = $urandom_range(0, 480);
      y = $urandom_range(0, 272);
      if (sel < 6) begin
        // mostly around the shown pair so hits happen
        it = mk_reg(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : cur_page,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : cur_layer,
                    $urandom_range(0, x), $urandom_range(0, y),
                    $urandom_range(x, 1023), $urandom_range(y, 1023), $urandom_range(0, 15));
        if (sel == 0) it = rand_fields();
        if (sel == 0) it.action = ACT_REG;
      end else if (sel < 9) begin
        it = mk_unreg(($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : cur_page,
                      ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : cur_layer,
                      $urandom_range(0, 15));
      end else if (sel < 18) begin
        it = mk_touch(x, y);
      end else if (sel == 18) begin
        it = rand_fields();
        it.action = ACT_TOUCH;
      end else begin
        it = rand_fields();
        it.action = 2'd3;
      end
      pending_items.push_back(it);
    end
    drain_req = 0;
  endtask

  initial begin
    in_item_t it;
    for (int i = 0; i < NPAGES*NLAYERS*NSLOTS; i++) elem_tbl[i] = '0;
    cur_page = 0;
    cur_layer = 0;
    cur_mask = 0;
    rst_n = 0;
    cfg_valid = 0;
    cfg_index = CFG_PAGE;
    cfg_data = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed: fill page 0 layer 0 with full-screen and edge rectangles
    pending_items.push_back(mk_reg(0, 0, 0, 0, 1023, 1023, 0));
    pending_items.push_back(mk_reg(0, 0, 100, 100, 50, 200, 1));  // inverted, never hit
    pending_items.push_back(mk_reg(0, 0, 0, 0, 0, 0, 15));
    for (int i = 0; i < 14; i++) pending_items.push_back(mk_reg(0, 0, 0, 0, 1023, 1023, i));
    pending_items.push_back(mk_touch(240, 136));   // fourteen hits
    pending_items.push_back(mk_touch(0, 0));
    it = rand_fields(); it.action = ACT_TOUCH; it.raw_first = 16'hFFFF; it.raw_second = 0;
    pending_items.push_back(it);
    it.raw_first = 0; it.raw_second = 16'hFFFF;    // raw x wraps past range
    pending_items.push_back(it);
    it.raw_first = 1024; it.raw_second = 0;
    pending_items.push_back(it);
    pending_items.push_back(mk_unreg(0, 0, 15));
    pending_items.push_back(mk_unreg(7, 3, 15));
    it = rand_fields(); it.action = 2'd3;
    pending_items.push_back(it);
    drain_req = 0;
    wait_idle();

    write_cfg(CFG_MASK, 16'hFFFF);
    write_cfg(CFG_PAGE, 16'hFFFF);
    write_cfg(CFG_LAYER, 16'hFFFF);
    pending_items.push_back(mk_reg(7, 3, 0, 0, 1023, 1023, 3));
    pending_items.push_back(mk_touch(480, 272));
    drain_req = 0;
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(CFG_PAGE, 16'((ph < 3) ? ph : $urandom_range(0, 7)));
      write_cfg(CFG_LAYER, 16'((ph < 3) ? ph : $urandom_range(0, 3)));
      write_cfg(CFG_MASK, (ph == 0) ? 16'h0000 : 16'($urandom) & 16'($urandom));
      run_phase(45);
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/trht_pkg.sv
hw/rtl/trht_mac.sv
hw/rtl/touch_region_hit_table_top.sv
hw/rtl/trht_checker.sv
dv/tb_touch_region_hit_table_top.sv
